/* sv/wgw_pkg.sv */
`default_nettype none
package wgw_pkg;

    localparam int PHASE_FRAC_BITS = 20;
    localparam int CORDIC_STEPS    = 20;
    localparam int UW              = PHASE_FRAC_BITS + 1;
    localparam int DIV_STAGES      = UW;
    localparam int QDEPTH          = 32;
    localparam int QAW             = $clog2(QDEPTH);
    localparam int QCW             = $clog2(QDEPTH + 1);
    localparam int CW              = 34;

    localparam logic [31:0]          TWO_PI_Q29  = 32'd3373259426;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic [31:0]          DUR_RESET   = 32'd655360;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_EOG  = 2'd1,
        MODE_ECD  = 2'd2,
        MODE_EDG  = 2'd3
    } t_mode;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODE = 2'd0;
    localparam t_cfg_idx CFG_AMP  = 2'd1;
    localparam t_cfg_idx CFG_DUR  = 2'd2;

    typedef struct packed {
        t_mode              mode;
        logic signed [23:0] amp;
        logic [31:0]        dur;
    } t_cfg;

    typedef struct packed {
        logic [UW-1:0] u;
        logic          inwin;
        logic          active;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic signed [CW-1:0] atan_step(input int i);
        logic signed [CW-1:0] v;
        v = '0;
        if (i <= 30) begin
            v = CW'(64'sd1 <<< (30 - i));
        end
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [31:0] r;
        r = 32'(v);
        if (v > Q30_ONE) begin
            r = 32'sd1073741824;
        end else if (v < -Q30_ONE) begin
            r = -32'sd1073741824;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/wgw_front.sv */
`default_nettype none
module wgw_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_acc,
    input  wire logic [31:0]    i_time,
    input  wgw_pkg::t_cfg       i_cfg,
    output logic                o_wr,
    output wgw_pkg::t_item      o_item
);
    import wgw_pkg::*;

    logic [DIV_STAGES:0] r_vld;
    logic [32:0]         r_rem [0:DIV_STAGES];
    logic [UW-1:0]       r_q   [0:DIV_STAGES];
    logic                r_inw [0:DIV_STAGES];
    logic                r_act [0:DIV_STAGES];
    logic                r_dz  [0:DIV_STAGES];
    logic                in_win;

    assign in_win = !i_time[31] && (i_time <= i_cfg.dur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_acc;
        end
        r_rem[0] <= {1'b0, i_time};
        r_q[0]   <= '0;
        r_inw[0] <= in_win;
        r_act[0] <= in_win && (i_cfg.mode != MODE_NONE);
        r_dz[0]  <= (i_cfg.dur == 32'd0);
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        logic [32:0] trial;
        logic        ge;
        always_comb begin
            trial = (j == 1) ? r_rem[j-1] : {r_rem[j-1][31:0], 1'b0};
            ge    = trial >= {1'b0, i_cfg.dur};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
            r_rem[j] <= ge ? (trial - {1'b0, i_cfg.dur}) : trial;
            r_q[j]   <= {r_q[j-1][UW-2:0], ge};
            r_inw[j] <= r_inw[j-1];
            r_act[j] <= r_act[j-1];
            r_dz[j]  <= r_dz[j-1];
        end
    end

    assign o_wr          = r_vld[DIV_STAGES];
    assign o_item.u      = r_dz[DIV_STAGES] ? '0 : r_q[DIV_STAGES];
    assign o_item.inwin  = r_inw[DIV_STAGES];
    assign o_item.active = r_act[DIV_STAGES];

endmodule
`default_nettype wire

/* sv/wgw_queue.sv */
`default_nettype none
module wgw_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire logic        i_wr,
    input  wgw_pkg::t_item   i_item,
    input  wire logic        i_pop,
    output wgw_pkg::t_item   o_item,
    output logic             o_space,
    output wgw_pkg::t_qstat  o_stat
);
    import wgw_pkg::*;

    t_item          r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt, r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt  <= r_cnt + QCW'(i_wr) - QCW'(i_pop);
            r_used <= r_used + QCW'(i_acc) - QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_space      = r_used < QCW'(QDEPTH);
    assign o_stat.full  = r_cnt == QCW'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule
`default_nettype wire

/* sv/wgw_back.sv */
`default_nettype none
module wgw_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wgw_pkg::t_cfg     i_cfg,
    input  wire logic         i_qv,
    input  wgw_pkg::t_item    i_item,
    output logic              o_pop,
    input  wire logic         i_m_tready,
    output logic              o_m_tvalid,
    output logic [23:0]       o_offset,
    output logic              o_inwin
);
    import wgw_pkg::*;

    logic en;

    logic [CORDIC_STEPS:0]  r_v;
    logic signed [CW-1:0]   r_x   [0:CORDIC_STEPS];
    logic signed [CW-1:0]   r_y   [0:CORDIC_STEPS];
    logic signed [CW-1:0]   r_z   [0:CORDIC_STEPS];
    logic [1:0]             r_qd  [0:CORDIC_STEPS];
    logic [UW-1:0]          r_u   [0:CORDIC_STEPS];
    logic                   r_inw [0:CORDIC_STEPS];
    logic                   r_act [0:CORDIC_STEPS];

    logic [UW-1:0]          angle;
    logic [UW+29:0]         zprod;

    logic                   r_vc, r_inwc, r_actc;
    logic [UW-1:0]          r_uc;
    logic signed [31:0]     r_s, r_c;
    logic signed [31:0]     xc, yc, s_n, c_n;

    logic                   r_vd, r_inwd;
    logic signed [31:0]     r_f, f_n;
    logic signed [UW+32:0]  eog_m;
    logic signed [32:0]     edg_d;

    logic                   r_ve, r_inwe;
    logic signed [55:0]     r_p;
    logic signed [55:0]     rnd;

    logic                   r_ov, r_oinw;
    logic [23:0]            r_ooff;

    assign en    = !r_ov || i_m_tready;
    assign o_pop = en && i_qv;

    always_comb begin
        if (i_cfg.mode == MODE_EOG) begin
            angle = UW'({i_item.u, 1'b0} + {1'b0, i_item.u});
        end else begin
            angle = {i_item.u[UW-2:0], 1'b0};
        end
        zprod = (UW+30)'(angle[UW-3:0]) * (UW+30)'(TWO_PI_Q29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= o_pop;
        end
        if (en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= signed'(CW'(zprod[PHASE_FRAC_BITS+30:PHASE_FRAC_BITS]));
            r_qd[0]  <= angle[UW-1:UW-2];
            r_u[0]   <= i_item.u;
            r_inw[0] <= i_item.inwin;
            r_act[0] <= i_item.active;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [CW-1:0] xs, ys;
        logic                 pos;
        always_comb begin
            xs  = r_x[i] >>> i;
            ys  = r_y[i] >>> i;
            pos = !r_z[i][CW-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (en) begin
                r_v[i+1] <= r_v[i];
            end
            if (en) begin
                r_x[i+1]   <= pos ? (r_x[i] - ys) : (r_x[i] + ys);
                r_y[i+1]   <= pos ? (r_y[i] + xs) : (r_y[i] - xs);
                r_z[i+1]   <= pos ? (r_z[i] - atan_step(i)) : (r_z[i] + atan_step(i));
                r_qd[i+1]  <= r_qd[i];
                r_u[i+1]   <= r_u[i];
                r_inw[i+1] <= r_inw[i];
                r_act[i+1] <= r_act[i];
            end
        end
    end

    always_comb begin
        xc = clamp_unit(r_x[CORDIC_STEPS]);
        yc = clamp_unit(r_y[CORDIC_STEPS]);
        case (r_qd[CORDIC_STEPS])
            2'd0:    begin c_n = xc;  s_n = yc;  end
            2'd1:    begin c_n = -yc; s_n = xc;  end
            2'd2:    begin c_n = -xc; s_n = -yc; end
            default: begin c_n = yc;  s_n = -xc; end
        endcase
    end

    always_comb begin
        eog_m = $signed({1'b0, (UW'(1) << PHASE_FRAC_BITS) - r_uc}) * r_s;
        edg_d = 33'(Q30_ONE) - 33'(r_c);
        unique case (i_cfg.mode)
            MODE_EOG: f_n = 32'(eog_m >>> PHASE_FRAC_BITS);
            MODE_ECD: f_n = r_s;
            MODE_EDG: f_n = 32'(edg_d >>> 1);
            default:  f_n = '0;
        endcase
        if (!r_actc) begin
            f_n = '0;
        end
        rnd = r_p + 56'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vc <= r_v[CORDIC_STEPS];
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_ov <= r_ve;
        end
        if (en) begin
            r_s    <= s_n;
            r_c    <= c_n;
            r_uc   <= r_u[CORDIC_STEPS];
            r_inwc <= r_inw[CORDIC_STEPS];
            r_actc <= r_act[CORDIC_STEPS];
            r_f    <= f_n;
            r_inwd <= r_inwc;
            r_p    <= i_cfg.amp * r_f;
            r_inwe <= r_inwd;
            r_ooff <= 24'(rnd >>> 30);
            r_oinw <= r_inwe;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_offset   = r_ooff;
    assign o_inwin    = r_oinw;

endmodule
`default_nettype wire

/* sv/wind_gust_waveform_top.sv */
// Wind gust waveform: one gust sample per input transaction.
// Slave channel: i_s_tdata carries the signed Q16.16 sample time.
// Master channel: o_m_tdata carries the signed Q8.16 gust offset and the window flag.
// Configuration: write mode (index 0), amplitude (index 1), duration (index 2)
// with i_cfg_wen while no transaction is in flight; writes take effect at once.
// Path from input to output: the front divider, the queue, and the back end
// (angle scale, 20 CORDIC rotations, quadrant fold, shape, amplitude, round).
// Throughput: one transaction per cycle while the receiver keeps accepting,
// set by the fully pipelined divider and CORDIC.
// When the receiver stalls, the back end holds and the 32-entry queue fills;
// o_s_tready drops once 32 transactions are accepted but not yet in the back end.
// Reset clears the pipelines and queue and restores mode none, amplitude zero
// and a 10 s duration; o_s_tready stays low while reset is held.
`default_nettype none
module wind_gust_waveform_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] sample_time
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [23:0] gust_offset, [24] in_window
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);
    import wgw_pkg::*;

    t_cfg   r_cfg;
    t_item  front_item, q_item;
    t_qstat qstat;
    logic   acc, front_wr, pop, qspace, inwin;
    logic [23:0] offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_NONE;
            r_cfg.amp  <= '0;
            r_cfg.dur  <= DUR_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_cfg.mode <= t_mode'(i_cfg_wdata[1:0]);
                CFG_AMP:  r_cfg.amp  <= signed'(i_cfg_wdata[23:0]);
                CFG_DUR:  r_cfg.dur  <= i_cfg_wdata;
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    assign o_s_tready = qspace && i_rst_n;
    assign acc        = i_s_tvalid && o_s_tready;

    wgw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_time  (i_s_tdata),
        .i_cfg   (r_cfg),
        .o_wr    (front_wr),
        .o_item  (front_item)
    );

    wgw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_wr    (front_wr),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_space (qspace),
        .o_stat  (qstat)
    );

    wgw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_qv       (!qstat.empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_offset   (offset),
        .o_inwin    (inwin)
    );

    assign o_m_tdata = {7'd0, inwin, offset};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_wr |-> !qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[24]) |-> (o_m_tdata[23:0] == 24'd0))
        else $error("nonzero offset outside window");

endmodule
`default_nettype wire
